### rtl/tvdp_pkg.sv
package tvdp_pkg;

  localparam int unsigned VIDEO_MEMORY_DEPTH = 16384;
  localparam int unsigned ADDR_W = $clog2(VIDEO_MEMORY_DEPTH);

  // Beam geometry
  localparam logic [8:0] H_LAST      = 9'd299;
  localparam logic [8:0] V_FRAME     = 9'd243;
  localparam logic [8:0] V_LAST      = 9'd339;
  localparam logic [8:0] TOP_BORDER  = 9'd27;
  localparam logic [8:0] BOTTOM_EDGE = 9'd219;
  localparam logic [8:0] LEFT_BORDER = 9'd13;
  localparam logic [8:0] RIGHT_EDGE  = 9'd269;
  localparam logic [8:0] LEFT_TEXT   = 9'd19;
  localparam logic [8:0] RIGHT_TEXT  = 9'd259;

  // Display modes
  localparam logic [2:0] MODE_G1    = 3'd0;
  localparam logic [2:0] MODE_G2    = 3'd1;
  localparam logic [2:0] MODE_MC    = 3'd2;
  localparam logic [2:0] MODE_TEXT  = 3'd4;

  // Register selects
  localparam logic [6:0] REG_MODE0  = 7'd0;
  localparam logic [6:0] REG_CTRL1  = 7'd1;
  localparam logic [6:0] REG_NAME   = 7'd2;
  localparam logic [6:0] REG_COLOUR = 7'd3;
  localparam logic [6:0] REG_PATT   = 7'd4;
  localparam logic [6:0] REG_TEXT   = 7'd7;

  localparam logic CMD_TICK = 1'b0;
  localparam logic PORT_DATA = 1'b0;

  typedef struct packed {
    logic       cmd;
    logic       port;
    logic       write_access;
    logic [7:0] host_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [3:0] pixel_colour;
    logic       irq_n;
    logic       frame_done;
  } out_word_t;

  // Memory request from the sequencer
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

### rtl/tile_video_display_processor.sv
// Tile video display processor, sprites not included.
// A host access makes at most one access to the video memory; a tick makes up to
// three dependent reads of the single-port video memory. busy is high while a word
// is worked on, so a new word is taken only once the last one is through.
// Reset: synchronous, active high; then a clearing pass zeroes every location of
// the video memory, with busy held high throughout.
module tile_video_display_processor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tvdp_pkg::in_word_t   in_word,
  output logic                 busy,
  output logic                 strobe,
  output tvdp_pkg::out_word_t  out_word
);
  import tvdp_pkg::*;

  localparam int unsigned AW = ADDR_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_RD3   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_HOST  = 3'd6;

  logic [2:0]  state, state_next;
  logic [AW:0] clr_cnt;
  mem_req_t    req;
  logic [7:0]  rdata;

  logic [15:0] address_latch;
  logic [7:0]  first_byte_latch;
  logic        awaiting_first_byte;
  logic        frame_flag;
  logic        irq_line_n;
  logic [2:0]  display_mode;
  logic [7:0]  control_one;
  logic [3:0]  name_base;
  logic [7:0]  colour_base;
  logic [7:0]  pattern_base;
  logic [7:0]  text_colours;
  logic [8:0]  beam_x, beam_y;

  // pixel job registers
  logic [7:0]  ax, ay, tx;
  logic [7:0]  name_byte, pat_byte;
  logic        host_rd, host_rd_next;
  out_word_t   res, res_next;

  tvdp_vram u_vram (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  // Beam advance and active area for an incoming tick
  logic [8:0] bx_n, by_n;
  logic       wrap_y, hit_frame, act;
  always_comb begin
    bx_n = beam_x + 9'd1;
    by_n = beam_y;
    wrap_y = 1'b0;
    hit_frame = 1'b0;
    if (beam_x == H_LAST) begin
      bx_n = '0;
      by_n = beam_y + 9'd1;
      if (by_n == V_FRAME) hit_frame = 1'b1;
      else if (beam_y == V_LAST) begin
        by_n = '0;
        wrap_y = 1'b1;
      end
    end
    act = control_one[6] && by_n >= TOP_BORDER && by_n < BOTTOM_EDGE &&
          ((display_mode == MODE_TEXT) ? (bx_n >= LEFT_TEXT && bx_n < RIGHT_TEXT)
                                       : (bx_n >= LEFT_BORDER && bx_n < RIGHT_EDGE));
  end

  // Table addresses for the current pixel
  logic [13:0] nt, pt, ct, blk, name_addr, a2, a3, off;
  logic [7:0]  tdiv;
  logic [2:0]  tmod;
  logic [7:0]  name_cur;
  always_comb begin
    // name byte arrives on rdata during the second read
    name_cur = (state == S_RD2) ? rdata : name_byte;
    nt   = {name_base, 10'd0};
    pt   = {pattern_base[2:0], 11'd0};
    ct   = {colour_base, 6'd0};
    blk  = {4'd0, ay[7:3], ax[7:3]};
    // tx / 6 as tx * 171 >> 10, exact for 8-bit tx
    tdiv = 8'((16'(tx) * 16'd171) >> 10);
    tmod = 3'(tx - 8'(tdiv * 8'd6));
    if (display_mode == MODE_TEXT)
      name_addr = nt + 14'(ay[7:3]) * 14'd40 + 14'(tdiv);
    else
      name_addr = nt + blk;
    off = {1'b0, blk[9:8], 11'd0} + {3'd0, name_cur, 3'd0} + 14'(ay[2:0]);
    a2 = '0;
    a3 = '0;
    unique case (display_mode)
      MODE_TEXT: a2 = pt + {3'd0, name_cur, 3'd0} + 14'(ay[2:0]);
      MODE_G1: begin
        a2 = ct + 14'(name_cur[7:3]);
        a3 = pt + {3'd0, name_cur, 3'd0} + 14'(ay[2:0]);
      end
      MODE_G2: begin
        a2 = {pattern_base[2], 13'd0} + off;
        a3 = {colour_base[7], 13'd0} + off;
      end
      MODE_MC: a2 = pt + {3'd0, name_cur, 3'd0} + {11'd0, ay[4:3], 1'b0} +
                    14'(ay[2]);
      default: ;
    endcase
  end

  // Memory request
  always_comb begin
    req = '0;
    if (state == S_CLEAR) begin
      req.en = 1'b1;
      req.we = 1'b1;
      req.addr = clr_cnt[AW-1:0];
    end else if (state == S_IDLE && start && in_word.cmd != CMD_TICK &&
                 in_word.port == PORT_DATA) begin
      req.en = 1'b1;
      req.we = in_word.write_access;
      req.addr = address_latch[AW-1:0];
      req.wdata = in_word.host_data;
    end else if (state == S_RD1) begin
      req.en = 1'b1;
      req.addr = name_addr;
    end else if (state == S_RD2) begin
      req.en = 1'b1;
      req.addr = a2;
    end else if (state == S_RD3) begin
      req.en = 1'b1;
      req.addr = a3;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == (AW+1)'(VIDEO_MEMORY_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: if (start) begin
        if (in_word.cmd != CMD_TICK) state_next = S_HOST;
        else if (act && (display_mode == MODE_TEXT || display_mode == MODE_G1 ||
                         display_mode == MODE_G2 || display_mode == MODE_MC))
          state_next = S_RD1;
        else state_next = S_DONE;
      end
      S_RD1: state_next = S_RD2;
      S_RD2: state_next = (display_mode == MODE_G1 || display_mode == MODE_G2) ?
                          S_RD3 : S_DONE;
      S_RD3: state_next = S_DONE;
      S_DONE, S_HOST: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // Colour pick from the last read
  logic [3:0] colour;
  logic [7:0] cbyte, pbyte;
  always_comb begin
    colour = text_colours[3:0];
    cbyte = rdata;
    pbyte = pat_byte;
    unique case (display_mode)
      MODE_TEXT: colour = rdata[3'd7 - tmod] ? text_colours[7:4] : text_colours[3:0];
      MODE_G1, MODE_G2: begin
        // G1: pattern is last, colour before; G2: colour is last
        if (display_mode == MODE_G1) begin
          pbyte = rdata;
          cbyte = pat_byte;
        end
        colour = pbyte[3'd7 - ax[2:0]] ? cbyte[7:4] : cbyte[3:0];
      end
      MODE_MC: colour = ax[2] ? rdata[3:0] : rdata[7:4];
      default: ;
    endcase
  end

  // Result word build-up
  always_comb begin
    res_next = res;
    host_rd_next = host_rd;
    unique case (state)
      S_IDLE: if (start) begin
        res_next = '0;
        host_rd_next = 1'b0;
        if (in_word.cmd != CMD_TICK) begin
          res_next.irq_n = irq_line_n;
          if (in_word.port == PORT_DATA) begin
            host_rd_next = !in_word.write_access;
          end else if (!in_word.write_access) begin
            // status read
            res_next.read_data = {frame_flag, 7'd0};
            res_next.irq_n = 1'b1;
          end
        end else begin
          if (hit_frame) res_next.irq_n = 1'b0;
          else if (wrap_y) res_next.irq_n = 1'b1;
          else res_next.irq_n = irq_line_n;
          res_next.frame_done = wrap_y;
          res_next.pixel_valid = act;
          if (act) begin
            res_next.pixel_x = 8'(bx_n - LEFT_BORDER);
            res_next.pixel_y = 8'(by_n - TOP_BORDER);
            res_next.pixel_colour = text_colours[3:0];
          end
        end
      end
      S_DONE: begin
        if (res.pixel_valid &&
            (display_mode == MODE_TEXT || display_mode == MODE_G1 ||
             display_mode == MODE_G2 || display_mode == MODE_MC))
          res_next.pixel_colour = colour;
      end
      S_HOST: if (host_rd) res_next.read_data = rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      strobe <= 1'b0;
      res <= '0;
      host_rd <= 1'b0;
      address_latch <= '0;
      first_byte_latch <= '0;
      awaiting_first_byte <= 1'b1;
      frame_flag <= 1'b0;
      irq_line_n <= 1'b1;
      display_mode <= '0;
      control_one <= '0;
      name_base <= '0;
      colour_base <= '0;
      pattern_base <= '0;
      text_colours <= '0;
      beam_x <= '0;
      beam_y <= '0;
    end else begin
      state <= state_next;
      strobe <= (state == S_DONE || state == S_HOST);
      res <= res_next;
      host_rd <= host_rd_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      unique case (state)
        S_IDLE: if (start) begin
          if (in_word.cmd != CMD_TICK) begin
            if (in_word.port == PORT_DATA) begin
              address_latch <= {address_latch[15:14], address_latch[13:0] + 14'd1};
            end else if (in_word.write_access) begin
              if (awaiting_first_byte) begin
                first_byte_latch <= in_word.host_data;
                awaiting_first_byte <= 1'b0;
              end else begin
                awaiting_first_byte <= 1'b1;
                if (in_word.host_data[7]) begin
                  case (in_word.host_data[6:0])
                    REG_MODE0: display_mode[0] <= first_byte_latch[1];
                    REG_CTRL1: begin
                      control_one <= first_byte_latch;
                      display_mode[2:1] <= first_byte_latch[4:3];
                    end
                    REG_NAME:   name_base <= first_byte_latch[3:0];
                    REG_COLOUR: colour_base <= first_byte_latch;
                    REG_PATT:   pattern_base <= first_byte_latch;
                    REG_TEXT:   text_colours <= first_byte_latch;
                    default: ;
                  endcase
                end else begin
                  address_latch <= {in_word.host_data, first_byte_latch};
                end
              end
            end else begin
              frame_flag <= 1'b0;
              irq_line_n <= 1'b1;
            end
          end else begin
            beam_x <= bx_n;
            beam_y <= by_n;
            if (hit_frame) begin
              frame_flag <= 1'b1;
              irq_line_n <= 1'b0;
            end else if (wrap_y) begin
              frame_flag <= 1'b0;
              irq_line_n <= 1'b1;
            end
            ax <= 8'(bx_n - LEFT_BORDER);
            ay <= 8'(by_n - TOP_BORDER);
            tx <= 8'(bx_n - LEFT_TEXT);
          end
        end
        S_RD2: name_byte <= rdata;
        S_RD3: pat_byte <= rdata;
        default: ;
      endcase
    end
  end

  assign out_word = res;

endmodule

### rtl/tvdp_vram.sv
module tvdp_vram (
  input  logic                  clk,
  input  tvdp_pkg::mem_req_t    req,
  output logic [7:0]            rdata
);
  import tvdp_pkg::*;

  logic [7:0] mem [VIDEO_MEMORY_DEPTH];

  // Single port, read data registered
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end
      rdata <= mem[req.addr];
    end
  end

endmodule
